### design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape / UTF-8 check core.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_HEX1,
    MODE_WANT_BS,
    MODE_WANT_U,
    MODE_HEX2,
    MODE_UTF8
  } mode_t;

  // Error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_CTRL       = 4'd1;
  localparam logic [3:0] ERR_TRUNC_ESC  = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd3;
  localparam logic [3:0] ERR_TRUNC_HEX  = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd5;
  localparam logic [3:0] ERR_LONE_HIGH  = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd7;
  localparam logic [3:0] ERR_UNEXP_LOW  = 4'd8;
  localparam logic [3:0] ERR_BAD_LEAD   = 4'd9;
  localparam logic [3:0] ERR_TRUNC_UTF8 = 4'd10;
  localparam logic [3:0] ERR_BAD_CONT   = 4'd11;
  localparam logic [3:0] ERR_BAD_CP     = 4'd12;
  localparam logic [3:0] ERR_UNTERM     = 4'd13;

  // Queue between decoder and serialiser (power of two)
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One decoded burst: up to four bytes, or a single done/error status
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            status;
    logic            done;
    logic [3:0]      err;
  } burst_t;

endpackage

### design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Decoder: one byte or end marker per cycle while acc, each may push a burst.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic            cmd,
  input  logic [7:0]      in_byte,
  output logic            push,
  output jsu_pkg::burst_t burst
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [9:0]  hi_r, hi_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [7:0]  held_r [4];

  logic        held_we;
  logic [1:0]  held_idx;

  function automatic jsu_pkg::burst_t mk_err(input logic [3:0] code);
    jsu_pkg::burst_t b;
    b        = '0;
    b.status = 1'b1;
    b.err    = code;
    return b;
  endfunction

  function automatic jsu_pkg::burst_t mk_byte(input logic [7:0] v);
    jsu_pkg::burst_t b;
    b          = '0;
    b.bytes[0] = v;
    return b;
  endfunction

  function automatic jsu_pkg::burst_t emit_cp(input logic [20:0] cp);
    jsu_pkg::burst_t b;
    b = '0;
    if (cp <= 21'h7F) begin
      b.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      b.cnt_m1   = 2'd1;
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      b.cnt_m1   = 2'd2;
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      b.cnt_m1   = 2'd3;
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  // 5'd16 flags a non-hex character
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (c >= "0" && c <= "9")      v = {1'b0, c[3:0]};
    else if (c >= "a" && c <= "f") v = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") v = 5'(c - 8'h37);
    else                           v = 5'd16;
    return v;
  endfunction

  always_comb begin
    logic        clr;
    logic [4:0]  hv;
    logic [15:0] hx;
    logic [20:0] cpn;
    logic [20:0] pair;
    logic [20:0] minimum;

    mode_nxt = mode_r;
    hex_nxt  = hex_r;
    hcnt_nxt = hcnt_r;
    hi_nxt   = hi_r;
    need_nxt = need_r;
    seen_nxt = seen_r;
    cp_nxt   = cp_r;
    push     = 1'b0;
    burst    = '0;
    clr      = 1'b0;
    held_we  = 1'b0;
    held_idx = '0;
    hv       = hex_val(in_byte);
    hx       = {hex_r[11:0], hv[3:0]};
    cpn      = {cp_r[14:0], in_byte[5:0]};
    pair     = 21'h10000 + {1'b0, hi_r, hx[9:0]};
    minimum  = (need_r == 2'd1) ? 21'h80 : (need_r == 2'd2) ? 21'h800 : 21'h10000;

    if (cmd) begin
      push = 1'b1;
      clr  = 1'b1;
      unique case (mode_r)
        jsu_pkg::MODE_ESC:     burst = mk_err(jsu_pkg::ERR_TRUNC_ESC);
        jsu_pkg::MODE_HEX1:    burst = mk_err(jsu_pkg::ERR_TRUNC_HEX);
        jsu_pkg::MODE_WANT_BS,
        jsu_pkg::MODE_WANT_U,
        jsu_pkg::MODE_HEX2:    burst = mk_err(jsu_pkg::ERR_LONE_HIGH);
        jsu_pkg::MODE_UTF8:    burst = mk_err(jsu_pkg::ERR_TRUNC_UTF8);
        default:               burst = mk_err(jsu_pkg::ERR_UNTERM);
      endcase
    end else begin
      unique case (mode_r)
        jsu_pkg::MODE_ESC: begin
          mode_nxt = jsu_pkg::MODE_IDLE;
          push     = 1'b1;
          case (in_byte)
            8'h22, 8'h5C, 8'h2F: burst = mk_byte(in_byte);
            "b": burst = mk_byte(8'h08);
            "f": burst = mk_byte(8'h0C);
            "n": burst = mk_byte(8'h0A);
            "r": burst = mk_byte(8'h0D);
            "t": burst = mk_byte(8'h09);
            "u": begin
              push     = 1'b0;
              mode_nxt = jsu_pkg::MODE_HEX1;
              hex_nxt  = '0;
              hcnt_nxt = '0;
            end
            default: begin
              burst = mk_err(jsu_pkg::ERR_BAD_ESC);
              clr   = 1'b1;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          if (hv[4]) begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_BAD_HEX);
            clr   = 1'b1;
          end else if (hcnt_r != 2'd3) begin
            hex_nxt  = hx;
            hcnt_nxt = hcnt_r + 2'd1;
          end else if (mode_r == jsu_pkg::MODE_HEX1) begin
            hex_nxt  = hx;
            hcnt_nxt = '0;
            if (hx >= 16'hD800 && hx <= 16'hDBFF) begin
              hi_nxt   = hx[9:0];
              mode_nxt = jsu_pkg::MODE_WANT_BS;
            end else if (hx >= 16'hDC00) begin
              // also covers the private range above the surrogates: recheck
              if (hx <= 16'hDFFF) begin
                push  = 1'b1;
                burst = mk_err(jsu_pkg::ERR_UNEXP_LOW);
                clr   = 1'b1;
              end else begin
                push  = 1'b1;
                burst = emit_cp({5'd0, hx});
                clr   = 1'b1;
              end
            end else begin
              push  = 1'b1;
              burst = emit_cp({5'd0, hx});
              clr   = 1'b1;
            end
          end else begin
            push = 1'b1;
            clr  = 1'b1;
            if (hx < 16'hDC00 || hx > 16'hDFFF) burst = mk_err(jsu_pkg::ERR_BAD_LOW);
            else                                burst = emit_cp(pair);
          end
        end
        jsu_pkg::MODE_WANT_BS: begin
          if (in_byte != 8'h5C) begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_LONE_HIGH);
            clr   = 1'b1;
          end else begin
            mode_nxt = jsu_pkg::MODE_WANT_U;
          end
        end
        jsu_pkg::MODE_WANT_U: begin
          if (in_byte != "u") begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_LONE_HIGH);
            clr   = 1'b1;
          end else begin
            mode_nxt = jsu_pkg::MODE_HEX2;
            hex_nxt  = '0;
            hcnt_nxt = '0;
          end
        end
        jsu_pkg::MODE_UTF8: begin
          if (in_byte[7:6] != 2'b10) begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_BAD_CONT);
            clr   = 1'b1;
          end else begin
            held_we  = 1'b1;
            held_idx = seen_r + 2'd1;
            cp_nxt   = cpn;
            seen_nxt = seen_r + 2'd1;
            if (seen_nxt >= need_r) begin
              push = 1'b1;
              clr  = 1'b1;
              if (cpn < minimum || cpn > 21'h10FFFF ||
                  (cpn >= 21'hD800 && cpn <= 21'hDFFF)) begin
                burst = mk_err(jsu_pkg::ERR_BAD_CP);
              end else begin
                burst.cnt_m1 = need_r;
                for (int i = 0; i < 4; i++) begin
                  burst.bytes[i] = (2'(i) == held_idx) ? in_byte : held_r[i];
                end
              end
            end
          end
        end
        default: begin
          clr = 1'b1;
          if (in_byte == 8'h22) begin
            push       = 1'b1;
            burst      = '0;
            burst.status = 1'b1;
            burst.done = 1'b1;
          end else if (in_byte < 8'h20) begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_CTRL);
          end else if (in_byte == 8'h5C) begin
            clr      = 1'b0;
            mode_nxt = jsu_pkg::MODE_ESC;
            hex_nxt  = '0;
            hcnt_nxt = '0;
            hi_nxt   = '0;
            need_nxt = '0;
            seen_nxt = '0;
            cp_nxt   = '0;
          end else if (in_byte < 8'h80) begin
            push  = 1'b1;
            burst = mk_byte(in_byte);
          end else if (in_byte >= 8'hC2 && in_byte <= 8'hF4) begin
            clr      = 1'b0;
            mode_nxt = jsu_pkg::MODE_UTF8;
            held_we  = 1'b1;
            held_idx = '0;
            hex_nxt  = '0;
            hcnt_nxt = '0;
            hi_nxt   = '0;
            seen_nxt = '0;
            if (in_byte <= 8'hDF) begin
              need_nxt = 2'd1;
              cp_nxt   = {16'd0, in_byte[4:0]};
            end else if (in_byte <= 8'hEF) begin
              need_nxt = 2'd2;
              cp_nxt   = {17'd0, in_byte[3:0]};
            end else begin
              need_nxt = 2'd3;
              cp_nxt   = {18'd0, in_byte[2:0]};
            end
          end else begin
            push  = 1'b1;
            burst = mk_err(jsu_pkg::ERR_BAD_LEAD);
          end
        end
      endcase
    end

    if (clr) begin
      mode_nxt = jsu_pkg::MODE_IDLE;
      hex_nxt  = '0;
      hcnt_nxt = '0;
      hi_nxt   = '0;
      need_nxt = '0;
      seen_nxt = '0;
      cp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      hex_r  <= '0;
      hcnt_r <= '0;
      hi_r   <= '0;
      need_r <= '0;
      seen_r <= '0;
      cp_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      hcnt_r <= hcnt_nxt;
      hi_r   <= hi_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
      cp_r   <= cp_nxt;
    end
  end

  // held lead/continuation bytes, only read after being written this sequence
  always_ff @(posedge clk) begin
    if (acc && !cmd && held_we) begin
      held_r[held_idx] <= in_byte;
    end
  end

endmodule

### design/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short burst queue between decoder and serialiser.
// ----------------------------------------------------------------------------
module jsu_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jsu_pkg::burst_t wr_data,
  input  logic            pop,
  output jsu_pkg::burst_t head,
  output logic            empty,
  output logic            full
);

  jsu_pkg::burst_t              mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [jsu_pkg::QAW:0]        cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("burst queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH))
    else $error("burst queue count out of range");

endmodule

### design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serialiser: head burst to an output reg, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::burst_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r;
  logic       done_r;
  logic [3:0] err_r;
  logic       last_r;
  logic       load;
  logic       at_end;

  assign load   = !empty && (!valid_r || out_tready);
  assign at_end = (idx_r == head.cnt_m1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load)                 valid_r <= 1'b1;
      else if (out_tready)      valid_r <= 1'b0;
      if (load) idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head.status ? 8'd0 : head.bytes[idx_r];
      bvalid_r <= !head.status;
      done_r   <= head.done;
      err_r    <= head.err;
      last_r   <= at_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, err_r, byte_r};
  assign out_tuser  = {done_r, bvalid_r};
  assign out_tlast  = last_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !bvalid_r |-> last_r)
    else $error("status result not marked last");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> idx_r == 2'd0)
    else $error("byte index left mid-burst with empty queue");

  a_byte_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && bvalid_r |-> !done_r && err_r == jsu_pkg::ERR_NONE)
    else $error("byte result carries status");

endmodule

### design/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with UTF-8 validation, streaming in and out.
// ----------------------------------------------------------------------------
// Input channel in_*: one transaction per body byte (in_tuser[0] = 0) or an
// end-of-input marker (in_tuser[0] = 1). Output channel out_*: decoded bytes
// (out_tuser[0] set) or one done / error status result; out_tlast marks the
// last result caused by an input transaction.
// The decoder takes one transaction per cycle while its burst queue (four
// entries) has room; each transaction yields zero to four results. The
// serialiser emits one result per cycle while out_tready allows, so sustained
// throughput is one input per cycle for single-result traffic, otherwise
// bounded by the serialiser.
// Each result passes through the queue and then the output register to out_*.
// A completed raw UTF-8 sequence or \u escape is released as one burst.
// Reset (rst_n low, synchronous) clears the decoder to the start of a string
// body and empties the queue and output register.
// When the receiver stalls, the output register holds, the queue fills, and
// in_tready falls once it is full.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] error_code, [15:12] zero
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] string_done
  output logic        out_tlast
);

  jsu_pkg::burst_t burst;
  jsu_pkg::burst_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  logic            acc;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .cmd     (in_tuser[0]),
    .in_byte (in_tdata),
    .push    (push),
    .burst   (burst)
  );

  jsu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push && acc),
    .wr_data (burst),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### sim/json_string_unescape_utf8_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Self-checking bench for the JSON string unescaper with UTF-8 checking.
// Directed strings cover plain text, every escape, \u escapes and surrogate
// pairs, raw UTF-8 and each error. Random token streams follow. A behavioural
// decoder predicts every output transaction. The sender idles in bursts and
// the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_tb;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_END   = 1'b1;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = "u";
  // simple escape letters, one per byte lane
  localparam logic [63:0] ESC_CHARS = {"t", "r", "n", "f", "b", "/", CH_BSLASH, CH_QUOTE};

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    logic [3:0] err;
    logic       last;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] in_byte
  logic [0:0]  in_tuser = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] out_byte, [11:8] error_code, [15:12] zero
  logic [1:0]  out_tuser;       // [0] byte_valid, [1] string_done
  logic        out_tlast;

  json_string_unescape_utf8_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder state mirrored from the block
  jsu_pkg::mode_t dec_mode;
  logic [15:0]    hex_acc;
  logic [1:0]     hex_cnt;
  logic [9:0]     hi_bits;
  logic [7:0]     held [4];
  logic [1:0]     cont_need;
  logic [1:0]     cont_seen;
  logic [20:0]    cp_acc;

  decoded_t step_q[$];
  decoded_t decoded_q[$];
  decoded_t want;
  int       fail_count = 0;
  int       items_fed = 0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       stall_left = 0;

  function automatic void put_result(logic [7:0] b, logic v, logic d, logic [3:0] e);
    decoded_t r;
    r.data  = b;
    r.valid = v;
    r.done  = d;
    r.err   = e;
    r.last  = 1'b0;
    step_q  = {step_q, r};
  endfunction

  function automatic void put_byte(logic [7:0] b);
    put_result(b, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
  endfunction

  function automatic void reset_decoder();
    dec_mode  = jsu_pkg::MODE_IDLE;
    hex_acc   = '0;
    hex_cnt   = '0;
    hi_bits   = '0;
    cont_need = '0;
    cont_seen = '0;
    cp_acc    = '0;
  endfunction

  function automatic void raise_error(logic [3:0] code);
    reset_decoder();
    put_result(8'h00, 1'b0, 1'b0, code);
  endfunction

  function automatic void utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] b,
                                      output int n);
    b = '0;
    if (cp <= 21'h7F) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp <= 21'h7FF) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp <= 21'hFFFF) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      n = 4;
    end
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    logic [3:0][7:0] b;
    int n;
    utf8_encode(cp, b, n);
    for (int i = 0; i < n; i++) put_byte(b[i]);
  endfunction

  // 16 marks a non-hex character
  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  function automatic void decode_byte(logic [7:0] c);
    logic [4:0]  nib;
    logic [20:0] cp;
    logic [20:0] lowest;
    logic [1:0]  slot;
    case (dec_mode)
      jsu_pkg::MODE_ESC: begin
        dec_mode = jsu_pkg::MODE_IDLE;
        case (c)
          CH_QUOTE:  put_byte(CH_QUOTE);
          CH_BSLASH: put_byte(CH_BSLASH);
          "/":       put_byte("/");
          "b":       put_byte(8'h08);
          "f":       put_byte(8'h0C);
          "n":       put_byte(8'h0A);
          "r":       put_byte(8'h0D);
          "t":       put_byte(8'h09);
          CH_U: begin
            dec_mode = jsu_pkg::MODE_HEX1;
            hex_acc  = '0;
            hex_cnt  = '0;
          end
          default:   raise_error(jsu_pkg::ERR_BAD_ESC);
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        nib = hex_value(c);
        if (nib[4]) begin
          raise_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (hex_cnt < 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt = '0;
            cp = {5'd0, hex_acc};
            if (dec_mode == jsu_pkg::MODE_HEX1) begin
              if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                hi_bits  = hex_acc[9:0];
                dec_mode = jsu_pkg::MODE_WANT_BS;
              end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                raise_error(jsu_pkg::ERR_UNEXP_LOW);
              end else begin
                reset_decoder();
                emit_code_point(cp);
              end
            end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
              raise_error(jsu_pkg::ERR_BAD_LOW);
            end else begin
              cp = 21'h10000 + {hi_bits, hex_acc[9:0]};
              reset_decoder();
              emit_code_point(cp);
            end
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (c != CH_BSLASH) raise_error(jsu_pkg::ERR_LONE_HIGH);
        else dec_mode = jsu_pkg::MODE_WANT_U;
      end
      jsu_pkg::MODE_WANT_U: begin
        if (c != CH_U) begin
          raise_error(jsu_pkg::ERR_LONE_HIGH);
        end else begin
          dec_mode = jsu_pkg::MODE_HEX2;
          hex_acc  = '0;
          hex_cnt  = '0;
        end
      end
      jsu_pkg::MODE_UTF8: begin
        if (c[7:6] != 2'b10) begin
          raise_error(jsu_pkg::ERR_BAD_CONT);
        end else begin
          slot       = cont_seen + 2'd1;
          held[slot] = c;
          cp_acc     = {cp_acc[14:0], c[5:0]};
          cont_seen  = slot;
          if (cont_seen >= cont_need) begin
            lowest = (cont_need == 2'd1) ? 21'h80 : (cont_need == 2'd2) ? 21'h800 : 21'h10000;
            if (cp_acc < lowest || cp_acc > 21'h10FFFF ||
                (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF)) begin
              raise_error(jsu_pkg::ERR_BAD_CP);
            end else begin
              for (int i = 0; i <= cont_need; i++) put_byte(held[i]);
              reset_decoder();
            end
          end
        end
      end
      default: begin
        reset_decoder();
        if (c == CH_QUOTE) begin
          put_result(8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE);
        end else if (c < 8'h20) begin
          raise_error(jsu_pkg::ERR_CTRL);
        end else if (c == CH_BSLASH) begin
          dec_mode = jsu_pkg::MODE_ESC;
        end else if (c < 8'h80) begin
          put_byte(c);
        end else if (c < 8'hC2 || c > 8'hF4) begin
          raise_error(jsu_pkg::ERR_BAD_LEAD);
        end else begin
          if (c <= 8'hDF) begin
            cont_need = 2'd1;
            cp_acc    = {16'd0, c[4:0]};
          end else if (c <= 8'hEF) begin
            cont_need = 2'd2;
            cp_acc    = {17'd0, c[3:0]};
          end else begin
            cont_need = 2'd3;
            cp_acc    = {18'd0, c[2:0]};
          end
          held[0]   = c;
          cont_seen = '0;
          dec_mode  = jsu_pkg::MODE_UTF8;
        end
      end
    endcase
  endfunction

  // Works out the results of one accepted transaction and queues them
  function automatic void unescape_step(logic cmd, logic [7:0] c);
    step_q.delete();
    if (cmd == CMD_END) begin
      case (dec_mode)
        jsu_pkg::MODE_ESC:    raise_error(jsu_pkg::ERR_TRUNC_ESC);
        jsu_pkg::MODE_HEX1:   raise_error(jsu_pkg::ERR_TRUNC_HEX);
        jsu_pkg::MODE_WANT_BS,
        jsu_pkg::MODE_WANT_U,
        jsu_pkg::MODE_HEX2:   raise_error(jsu_pkg::ERR_LONE_HIGH);
        jsu_pkg::MODE_UTF8:   raise_error(jsu_pkg::ERR_TRUNC_UTF8);
        default:              raise_error(jsu_pkg::ERR_UNTERM);
      endcase
    end else begin
      decode_byte(c);
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    decoded_q = {decoded_q, step_q};
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic feed(input logic cmd, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    unescape_step(cmd, c);
    burst_left--;
    items_fed++;
  endtask

  task automatic feed_byte(input logic [7:0] c);
    feed(CMD_BYTE, c);
  endtask

  task automatic feed_end();
    feed(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 4'd10);
  endfunction

  task automatic feed_u(input logic [15:0] v);
    feed_byte(CH_BSLASH);
    feed_byte(CH_U);
    for (int i = 3; i >= 0; i--) feed_byte(hex_char(v[4*i +: 4]));
  endtask

  // above the BMP the code point goes out as a surrogate pair
  task automatic feed_u_cp(input logic [20:0] cp);
    logic [19:0] off;
    if (cp > 21'hFFFF) begin
      off = 20'(cp - 21'h10000);
      feed_u({6'b110110, off[19:10]});
      feed_u({6'b110111, off[9:0]});
    end else begin
      feed_u(cp[15:0]);
    end
  endtask

  task automatic feed_utf8(input logic [20:0] cp);
    logic [3:0][7:0] b;
    int n;
    utf8_encode(cp, b, n);
    for (int i = 0; i < n; i++) feed_byte(b[i]);
  endtask

  function automatic logic [20:0] random_cp(int min_len, int max_len);
    case ($urandom_range(min_len, max_len))
      1:       return 21'($urandom_range(0, 'h7F));
      2:       return 21'($urandom_range('h80, 'h7FF));
      3:       return $urandom_range(0, 1) ? 21'($urandom_range('h800, 'hD7FF))
                                           : 21'($urandom_range('hE000, 'hFFFF));
      default: return 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  // Malformed or cut-short sequences with random content
  task automatic feed_broken();
    logic [3:0][7:0] b;
    int n;
    case ($urandom_range(0, 7))
      0: begin
        utf8_encode(random_cp(2, 4), b, n);
        for (int i = 0; i < n - 1; i++) feed_byte(b[i]);
        feed_byte(8'($urandom_range(0, 8'h7F)));
      end
      1: begin
        if ($urandom_range(0, 1)) begin
          feed_byte(8'hE0);
          feed_byte(8'($urandom_range(8'h80, 8'h9F)));
        end else begin
          feed_byte(8'hF0);
          feed_byte(8'($urandom_range(8'h80, 8'h8F)));
          feed_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        feed_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      2: begin
        feed_byte(8'hED);
        feed_byte(8'($urandom_range(8'hA0, 8'hBF)));
        feed_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      3: begin
        feed_byte(8'hF4);
        feed_byte(8'($urandom_range(8'h90, 8'hBF)));
        feed_byte(8'($urandom_range(8'h80, 8'hBF)));
        feed_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      4: begin
        feed_byte(CH_BSLASH);
        feed_byte(CH_U);
        repeat ($urandom_range(0, 3)) feed_byte(hex_char(4'($urandom_range(0, 15))));
        feed_byte(8'($urandom_range("g", "z")));
      end
      5: begin
        feed_u(16'($urandom_range('hD800, 'hDBFF)));
        case ($urandom_range(0, 2))
          0: feed_byte(8'($urandom_range("A", "Z")));
          1: begin
            feed_byte(CH_BSLASH);
            feed_byte("n");
          end
          default: feed_u(random_cp(1, 3) < 21'h800 ? 16'hDBFF : 16'h0041);
        endcase
      end
      6: feed_u(16'($urandom_range('hDC00, 'hDFFF)));
      default: begin
        // partial sequence cut off by the end marker
        case ($urandom_range(0, 3))
          0: feed_byte(CH_BSLASH);
          1: begin
            feed_byte(CH_BSLASH);
            feed_byte(CH_U);
            repeat ($urandom_range(0, 3)) feed_byte(hex_char(4'($urandom_range(0, 15))));
          end
          2: begin
            utf8_encode(random_cp(2, 4), b, n);
            for (int i = 0; i < $urandom_range(1, n - 1); i++) feed_byte(b[i]);
          end
          default: begin
            feed_u(16'($urandom_range('hD800, 'hDBFF)));
            if ($urandom_range(0, 1)) feed_byte(CH_BSLASH);
          end
        endcase
        feed_end();
      end
    endcase
  endtask

  // ------------------------------------------------------------------- tests

  task automatic check_plain_text();
    feed_byte(8'h20);
    feed_byte(8'h7F);
    feed_byte("A");
    feed_byte(CH_QUOTE);
    feed_byte(8'h00);
    feed_byte(8'h1F);
  endtask

  task automatic check_simple_escapes();
    for (int k = 0; k < 8; k++) begin
      feed_byte(CH_BSLASH);
      feed_byte(ESC_CHARS[8*k +: 8]);
    end
    feed_byte(CH_BSLASH);
    feed_byte("x");
  endtask

  task automatic check_unicode_escapes();
    feed_u(16'h0000);
    feed_u(16'h007F);
    feed_u(16'h0080);
    feed_u(16'h07FF);
    feed_u(16'h0800);
    feed_u(16'hFFFF);
    feed_u_cp(21'h10000);
    feed_u_cp(21'h10FFFF);
    feed_u(16'hDC00);
    // non-hex digit
    feed_byte(CH_BSLASH);
    feed_byte(CH_U);
    feed_byte("1");
    feed_byte("g");
    // high surrogate without a following escape, with a bad one, with a non-low one
    feed_u(16'hD800);
    feed_byte("a");
    feed_u(16'hDBFF);
    feed_byte(CH_BSLASH);
    feed_byte("x");
    feed_u(16'hD800);
    feed_u(16'h0041);
    feed_byte(CH_QUOTE);
  endtask

  task automatic check_raw_utf8();
    feed_utf8(21'h80);
    feed_utf8(21'h7FF);
    feed_utf8(21'h800);
    feed_utf8(21'hFFFF);
    feed_utf8(21'h10000);
    feed_utf8(21'h10FFFF);
    feed_byte(8'h80);
    feed_byte(8'hC1);
    feed_byte(8'hF5);
    feed_byte(8'hFF);
    feed_byte(8'hC3);
    feed_byte("A");
    // overlong, surrogate and out of range code points
    feed_byte(8'hE0); feed_byte(8'h80); feed_byte(8'h80);
    feed_byte(8'hED); feed_byte(8'hA0); feed_byte(8'h80);
    feed_byte(8'hF4); feed_byte(8'h90); feed_byte(8'h80); feed_byte(8'h80);
  endtask

  task automatic check_end_of_input();
    feed_end();
    feed_byte(CH_BSLASH);
    feed_end();
    feed_byte(CH_BSLASH);
    feed_byte(CH_U);
    feed_byte("1");
    feed_end();
    feed_u(16'hD800);
    feed_end();
    feed_u(16'hD800);
    feed_byte(CH_BSLASH);
    feed_end();
    feed_u(16'hD800);
    feed_byte(CH_BSLASH);
    feed_byte(CH_U);
    feed_byte("D");
    feed_end();
    feed_byte(8'hC3);
    feed_end();
    feed_byte(8'hF0);
    feed_byte(8'h90);
    feed_end();
  endtask

  task automatic check_random_strings();
    int stop_at;
    int sel;
    bit paused;
    stop_at = items_fed + 24;
    paused  = 1'b0;
    while (items_fed < stop_at) begin
      if (!paused && items_fed >= stop_at - 12) begin
        drain_results();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        feed_byte(8'($urandom_range(8'h20, 8'h7F)));
      end else if (sel < 37) begin
        feed_byte(CH_BSLASH);
        feed_byte(ESC_CHARS[8*$urandom_range(0, 7) +: 8]);
      end else if (sel < 50) begin
        feed_u_cp(random_cp(1, 4));
      end else if (sel < 68) begin
        feed_utf8(random_cp(2, 4));
      end else if (sel < 75) begin
        feed_byte(CH_QUOTE);
      end else if (sel < 79) begin
        feed_end();
      end else if (sel < 85) begin
        feed_byte(8'($urandom_range(0, 255)));
      end else if (sel < 88) begin
        feed_byte(8'($urandom_range(0, 8'h1F)));
      end else begin
        feed_broken();
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Phases of free flow, random stalls, long stalls and alternation
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ~out_tready;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected transaction: tdata %h tuser %b tlast %b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[11:8] !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_tdata[11:8]);
          fail_count++;
        end
        if (out_tdata[15:12] !== 4'd0) begin
          $error("tdata padding: expected 0, got %h", out_tdata[15:12]);
          fail_count++;
        end
        if (out_tuser[0] !== want.valid) begin
          $error("byte_valid: expected %b, got %b", want.valid, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== want.done) begin
          $error("string_done: expected %b, got %b", want.done, out_tuser[1]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ control

  initial begin
    reset_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_plain_text();
    check_simple_escapes();
    check_unicode_escapes();
    check_raw_utf8();
    check_end_of_input();
    check_random_strings();
    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("json_string_unescape_utf8_core: match");
    end else begin
      $display("json_string_unescape_utf8_core: mismatch");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin
    #5ms;
    $display("json_string_unescape_utf8_core: mismatch");
    $finish;
  end

endmodule
